// ===== design/ist_pkg.sv =====
// Shared types and constants for the interpolation slot engine.
// No dependencies; imported by every design module.
package ist_pkg;

   localparam int SLOT_COUNT   = 16;
   localparam int COORD_BITS   = 16;
   localparam int SLOT_BITS    = $clog2(SLOT_COUNT);
   localparam int LINK_BITS    = $clog2(SLOT_COUNT + 1);
   localparam int CMD_BITS     = 2;
   localparam int SLOT_FIELD   = 4;
   localparam int STATE_FIELD  = 2;
   localparam int TIME_BITS    = 16;
   localparam int ELAPSED_BITS = TIME_BITS + 1;
   localparam int TAG_BITS     = 32;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = COORD_BITS + TIME_BITS;
   localparam int CNT_BITS     = $clog2(COORD_BITS);
   localparam logic [TIME_BITS-1:0] TIME_MAX = 16'hffff;

   // request item layout, lowest bit first (command travels in tuser)
   localparam int REQ_SLOT_LO  = 0;
   localparam int REQ_NS_LO    = REQ_SLOT_LO + SLOT_FIELD;
   localparam int REQ_DELTA_LO = REQ_NS_LO + STATE_FIELD;
   localparam int REQ_DUR_LO   = REQ_DELTA_LO + TIME_BITS;
   localparam int REQ_TAG_LO   = REQ_DUR_LO + TIME_BITS;
   localparam int REQ_SX_LO    = REQ_TAG_LO + TAG_BITS;
   localparam int REQ_SY_LO    = REQ_SX_LO + COORD_BITS;
   localparam int REQ_EX_LO    = REQ_SY_LO + COORD_BITS;
   localparam int REQ_EY_LO    = REQ_EX_LO + COORD_BITS;
   localparam int REQ_FIELDS   = REQ_EY_LO + COORD_BITS;
   localparam int REQ_DATA_BITS = ((REQ_FIELDS + 7) / 8) * 8;

   // response item layout, lowest bit first
   localparam int RSP_OK_LO    = 0;
   localparam int RSP_SLOT_LO  = 1;
   localparam int RSP_TAG_LO   = RSP_SLOT_LO + SLOT_FIELD;
   localparam int RSP_VX_LO    = RSP_TAG_LO + TAG_BITS;
   localparam int RSP_VY_LO    = RSP_VX_LO + COORD_BITS;
   localparam int RSP_FIELDS   = RSP_VY_LO + COORD_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELDS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_SET     = 2'd1,
      CMD_ADVANCE = 2'd2,
      CMD_READ    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      MODE_FREE  = 2'd0,
      MODE_PLAY  = 2'd1,
      MODE_PAUSE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_FINISH = 2'd1,
      KIND_DONE   = 2'd2,
      KIND_VALUE  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SET,
      ST_READ,
      ST_ADV_CHECK,
      ST_ADV_EVENT,
      ST_ADV_MUL,
      ST_ADV_DIV,
      ST_ADV_STORE,
      ST_ADV_DONE
   } state_type;

   typedef struct packed {
      logic                 capture;
      logic                 do_start;
      logic                 do_set;
      logic                 adv_eval;
      logic                 release_slot;
      logic                 mul;
      logic                 div_step;
      logic                 store_lerp;
      logic                 emit;
      kind_type             emit_kind;
      logic                 use_scan;
      logic [SLOT_BITS-1:0] scan_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic        head_end;
      logic        play;
      logic        done;
      logic        tag_nz;
      logic        out_free;
   } ctl_status_type;

endpackage

// ===== design/ist_datapath.sv =====
// Slot stores, free list, multiply/divide lanes and response register.
// Depends on ist_pkg; driven by ist_controller commands.
module ist_datapath import ist_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  ctl_cmd_type              cmd,
   output ctl_status_type           status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tlast
);

   mode_type                   mode_ff [SLOT_COUNT];
   logic [LINK_BITS-1:0]       link_ff [SLOT_COUNT];
   logic [LINK_BITS-1:0]       head_ff, head_in;
   logic                       rsp_valid_ff;

   logic [TAG_BITS-1:0]        tag_ff  [SLOT_COUNT];
   logic [TIME_BITS-1:0]       len_ff  [SLOT_COUNT];
   logic [ELAPSED_BITS-1:0]    ela_ff  [SLOT_COUNT];
   logic signed [COORD_BITS-1:0] org_ff [SLOT_COUNT][2];
   logic signed [COORD_BITS-1:0] tgt_ff [SLOT_COUNT][2];
   logic signed [COORD_BITS-1:0] pre_ff [SLOT_COUNT][2];

   logic [SLOT_FIELD-1:0]      slot_ff;
   logic [STATE_FIELD-1:0]     ns_ff;
   logic [TIME_BITS-1:0]       delta_ff, dur_ff, el_ff;
   logic [TAG_BITS-1:0]        tagin_ff;
   logic signed [COORD_BITS-1:0] st_pt_ff [2];
   logic signed [COORD_BITS-1:0] en_pt_ff [2];

   logic [TIME_BITS:0]         rem_ff [2];
   logic [COORD_BITS-1:0]      quo_ff [2];
   logic                       neg_ff [2];

   logic [RSP_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]                 rsp_user_ff;
   logic                       rsp_last_ff;

   logic [SLOT_BITS-1:0]       idx, head_idx;
   logic                       head_end, out_free, rel, set_mode;
   logic [ELAPSED_BITS-1:0]    el_sum;
   logic                       el_done;
   logic [DIFF_BITS-1:0]       diff [2];
   logic [DIFF_BITS-1:0]       mag [2];
   logic [PROD_BITS-1:0]       prod [2];
   logic [TIME_BITS:0]         trial [2];
   logic                       qbit [2];
   logic [DIFF_BITS-1:0]       qsig [2];
   logic [DIFF_BITS-1:0]       lerp [2];
   logic                       ok_bit;
   logic [SLOT_FIELD-1:0]      out_slot;
   logic [TAG_BITS-1:0]        out_tag;
   logic [COORD_BITS-1:0]      out_x, out_y;

   assign idx      = cmd.use_scan ? cmd.scan_idx : SLOT_BITS'(slot_ff);
   assign head_end = (head_ff == LINK_BITS'(SLOT_COUNT));
   assign head_idx = head_ff[SLOT_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign el_sum  = ela_ff[idx] + ELAPSED_BITS'(delta_ff);
   assign el_done = (el_sum >= {1'b0, len_ff[idx]});

   assign rel = cmd.release_slot ||
                (cmd.do_set && ns_ff == STATE_FIELD'(MODE_FREE) && mode_ff[idx] != MODE_FREE);
   assign set_mode = cmd.do_set && mode_ff[idx] != MODE_FREE &&
                     (ns_ff == STATE_FIELD'(MODE_PLAY) || ns_ff == STATE_FIELD'(MODE_PAUSE));

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         diff[l]  = {tgt_ff[idx][l][COORD_BITS-1], tgt_ff[idx][l]} -
                    {org_ff[idx][l][COORD_BITS-1], org_ff[idx][l]};
         mag[l]   = diff[l][DIFF_BITS-1] ? -diff[l] : diff[l];
         prod[l]  = PROD_BITS'(mag[l][COORD_BITS-1:0]) * PROD_BITS'(el_ff);
         trial[l] = {rem_ff[l][TIME_BITS-1:0], quo_ff[l][COORD_BITS-1]};
         qbit[l]  = (trial[l] >= {1'b0, len_ff[idx]});
         qsig[l]  = neg_ff[l] ? -{1'b0, quo_ff[l]} : {1'b0, quo_ff[l]};
         lerp[l]  = {org_ff[idx][l][COORD_BITS-1], org_ff[idx][l]} + qsig[l];
      end
   end

   always_comb begin
      head_in = head_ff;
      if (cmd.do_start)
         head_in = link_ff[head_idx];
      if (rel)
         head_in = LINK_BITS'(idx);
   end

   always_comb begin
      ok_bit   = 1'b1;
      out_slot = '0;
      out_tag  = '0;
      out_x    = '0;
      out_y    = '0;
      case (cmd.emit_kind)
         KIND_START: begin
            ok_bit   = !head_end;
            out_slot = head_end ? '0 : SLOT_FIELD'(head_idx);
         end
         KIND_FINISH: begin
            out_slot = SLOT_FIELD'(idx);
            out_tag  = tag_ff[idx];
         end
         KIND_VALUE: begin
            out_slot = slot_ff;
            out_x    = pre_ff[idx][0];
            out_y    = pre_ff[idx][1];
         end
         default: begin
            out_slot = '0;
         end
      endcase
      rsp_data_in = '0;
      rsp_data_in[RSP_OK_LO]                        = ok_bit;
      rsp_data_in[RSP_SLOT_LO +: SLOT_FIELD]        = out_slot;
      rsp_data_in[RSP_TAG_LO +: TAG_BITS]           = out_tag;
      rsp_data_in[RSP_VX_LO +: COORD_BITS]          = out_x;
      rsp_data_in[RSP_VY_LO +: COORD_BITS]          = out_y;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            mode_ff[i] <= MODE_FREE;
            link_ff[i] <= LINK_BITS'(i + 1);
         end
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         if (cmd.do_start)
            mode_ff[head_idx] <= MODE_PLAY;
         if (rel) begin
            mode_ff[idx] <= MODE_FREE;
            link_ff[idx] <= head_ff;
         end
         if (set_mode)
            mode_ff[idx] <= mode_type'(ns_ff);
         if (cmd.emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff     <= req_tdata[REQ_SLOT_LO +: SLOT_FIELD];
         ns_ff       <= req_tdata[REQ_NS_LO +: STATE_FIELD];
         delta_ff    <= req_tdata[REQ_DELTA_LO +: TIME_BITS];
         dur_ff      <= req_tdata[REQ_DUR_LO +: TIME_BITS];
         tagin_ff    <= req_tdata[REQ_TAG_LO +: TAG_BITS];
         st_pt_ff[0] <= req_tdata[REQ_SX_LO +: COORD_BITS];
         st_pt_ff[1] <= req_tdata[REQ_SY_LO +: COORD_BITS];
         en_pt_ff[0] <= req_tdata[REQ_EX_LO +: COORD_BITS];
         en_pt_ff[1] <= req_tdata[REQ_EY_LO +: COORD_BITS];
      end
      if (cmd.do_start) begin
         tag_ff[head_idx] <= tagin_ff;
         len_ff[head_idx] <= dur_ff & TIME_MAX;
         ela_ff[head_idx] <= '0;
         for (int l = 0; l < 2; l++) begin
            org_ff[head_idx][l] <= st_pt_ff[l];
            pre_ff[head_idx][l] <= st_pt_ff[l];
            tgt_ff[head_idx][l] <= en_pt_ff[l];
         end
      end
      if (cmd.adv_eval) begin
         ela_ff[idx] <= el_sum;
         el_ff       <= el_sum[TIME_BITS-1:0];
         if (el_done)
            for (int l = 0; l < 2; l++)
               pre_ff[idx][l] <= tgt_ff[idx][l];
      end
      for (int l = 0; l < 2; l++) begin
         if (cmd.mul) begin
            // quotient stays below the axis span, so the high half is already < length
            rem_ff[l] <= {1'b0, prod[l][PROD_BITS-1:COORD_BITS]};
            quo_ff[l] <= prod[l][COORD_BITS-1:0];
            neg_ff[l] <= diff[l][DIFF_BITS-1];
         end else if (cmd.div_step) begin
            rem_ff[l] <= qbit[l] ? trial[l] - {1'b0, len_ff[idx]} : trial[l];
            quo_ff[l] <= {quo_ff[l][COORD_BITS-2:0], qbit[l]};
         end
         if (cmd.store_lerp)
            pre_ff[idx][l] <= lerp[l][COORD_BITS-1:0];
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= cmd.emit_kind;
         rsp_last_ff <= (cmd.emit_kind != KIND_FINISH);
      end
   end

   assign status.head_end = head_end;
   assign status.play     = (mode_ff[idx] == MODE_PLAY);
   assign status.done     = el_done;
   assign status.tag_nz   = (tag_ff[idx] != '0);
   assign status.out_free = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free) else $error("item loaded over a pending response");
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LINK_BITS'(SLOT_COUNT)) else $error("free head out of range");
   a_start_plays: assert property (@(posedge clock) disable iff (reset)
      cmd.do_start && !head_end |=> mode_ff[$past(head_idx)] == MODE_PLAY)
      else $error("allocated slot not playing");

endmodule

// ===== design/ist_controller.sv =====
// Sequencer for request decode, the descending advance scan and the divider.
// Depends on ist_pkg; drives ist_datapath through ctl_cmd_type.
module ist_controller import ist_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CMD_BITS-1:0] req_tuser,
   input  ctl_status_type      status,
   output ctl_cmd_type         cmd
);

   state_type            state_ff, state_in;
   logic [SLOT_BITS-1:0] scan_ff, scan_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      cnt_in       = cnt_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.use_scan = 1'b1;
      cmd.scan_idx = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.use_scan = 1'b0;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (command_type'(req_tuser))
                  CMD_START:   state_in = ST_START;
                  CMD_SET:     state_in = ST_SET;
                  CMD_READ:    state_in = ST_READ;
                  CMD_ADVANCE: begin
                     state_in = ST_ADV_CHECK;
                     scan_in  = SLOT_BITS'(SLOT_COUNT - 1);
                  end
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_START: begin
            cmd.emit_kind = KIND_START;
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.do_start = !status.head_end;
               state_in     = ST_IDLE;
            end
         end
         ST_SET: begin
            cmd.use_scan  = 1'b0;
            cmd.emit_kind = KIND_DONE;
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.do_set = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.use_scan  = 1'b0;
            cmd.emit_kind = KIND_VALUE;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ADV_CHECK: begin
            if (status.play) begin
               cmd.adv_eval = 1'b1;
               // silent finishes release right away
               cmd.release_slot = status.done && !status.tag_nz;
            end
            if (status.play && !status.done)
               state_in = ST_ADV_MUL;
            else if (status.play && status.tag_nz)
               state_in = ST_ADV_EVENT;
            else if (scan_ff == '0)
               state_in = ST_ADV_DONE;
            else
               scan_in = scan_ff - 1'b1;
         end
         ST_ADV_EVENT: begin
            cmd.emit_kind = KIND_FINISH;
            if (status.out_free) begin
               cmd.emit         = 1'b1;
               cmd.release_slot = 1'b1;
               if (scan_ff == '0)
                  state_in = ST_ADV_DONE;
               else begin
                  scan_in  = scan_ff - 1'b1;
                  state_in = ST_ADV_CHECK;
               end
            end
         end
         ST_ADV_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_ADV_DIV;
         end
         ST_ADV_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(COORD_BITS - 1))
               state_in = ST_ADV_STORE;
         end
         ST_ADV_STORE: begin
            cmd.store_lerp = 1'b1;
            if (scan_ff == '0)
               state_in = ST_ADV_DONE;
            else begin
               scan_in  = scan_ff - 1'b1;
               state_in = ST_ADV_CHECK;
            end
         end
         ST_ADV_DONE: begin
            cmd.emit_kind = KIND_DONE;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/interpolation_slot_engine.sv =====
// Top level of the interpolation slot engine: controller plus datapath.
// Depends on ist_pkg, ist_controller, ist_datapath.
//
//  channel  dir  ports                               contents
//  req      in   req_tvalid/tready, tuser[1:0],      command;
//                tdata[135:0]                        slot,new_state,delta,duration,
//                                                    tag,sx,sy,ex,ey
//  rsp      out  rsp_tvalid/tready, tdata[71:0],      ok,slot_index,tag_out,vx,vy;
//                tuser[1:0], tlast                   kind; last
//
// One item at a time. Start, set and read each wait in their state for output space.
// Advance walks slots 15 down to 0, then emits done; a slot ending with a nonzero
// tag also emits a finish item, and an interpolating slot goes through multiply,
// divide (shared restoring divider, one quotient bit per cycle per axis) and store.
// Reset is synchronous; all slots free and the free list chained in order.
// A stalled response holds in the output register; work stops only when a
// new item must be loaded.
module interpolation_slot_engine import ist_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // command
   input  logic [CMD_BITS-1:0]      req_tuser,
   // slot, new_state, time_delta, duration, finish_tag,
   // start_x, start_y, end_x, end_y, zero pad
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // ok, slot_index, tag_out, value_x, value_y, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // kind
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tlast
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   ist_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   ist_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== test/ist_checker.sv =====
// Checker for the interpolation slot engine. It watches both streams, predicts the results
// of each accepted request item and compares every response item field by field.
// Depends on ist_pkg.
`timescale 1ns / 1ps
module ist_checker import ist_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [CMD_BITS-1:0]      req_tuser,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic [1:0]               rsp_tuser,
   input  logic                     rsp_tlast,
   output int                       failures,
   output int                       pending,
   output logic [SLOT_COUNT-1:0]    ever_started
);

   typedef struct {
      kind_type                kind;
      logic                    ok;
      logic [3:0]              slot_index;
      logic [TAG_BITS-1:0]     tag;
      logic [COORD_BITS-1:0]   vx;
      logic [COORD_BITS-1:0]   vy;
      logic                    last;
   } outcome_type;

   outcome_type         outcome_q[$];

   mode_type            mode_r[SLOT_COUNT];
   logic [4:0]          link_r[SLOT_COUNT];
   logic [4:0]          head_r;
   logic [4:0]          mark_r;
   logic [TAG_BITS-1:0] tag_r[SLOT_COUNT];
   logic [16:0]         length_r[SLOT_COUNT];
   logic [16:0]         elapsed_r[SLOT_COUNT];
   longint              org_x[SLOT_COUNT], org_y[SLOT_COUNT];
   longint              tgt_x[SLOT_COUNT], tgt_y[SLOT_COUNT];
   longint              cur_x[SLOT_COUNT], cur_y[SLOT_COUNT];

   function automatic void push_outcome(kind_type k, logic ok, logic [3:0] s,
                                        logic [31:0] t, longint x, longint y, logic l);
      outcome_type o;
      o.kind = k; o.ok = ok; o.slot_index = s; o.tag = t;
      o.vx = x[COORD_BITS-1:0]; o.vy = y[COORD_BITS-1:0]; o.last = l;
      outcome_q.push_back(o);
   endfunction

   function automatic void free_slot(int s);
      int top;
      mode_r[s] = MODE_FREE;
      link_r[s] = head_r;
      head_r    = 5'(s);
      if (mark_r != 0 && s == mark_r - 1) begin
         top = s;
         while (top > 0 && mode_r[top-1] == MODE_FREE) top--;
         mark_r = 5'(top);
      end
   endfunction

   function automatic longint lerp(longint a, longint b, longint el, longint len);
      return a + ((b - a) * el) / len;   // SV division truncates toward zero
   endfunction

   function automatic void predict_item(logic [CMD_BITS-1:0] u,
                                        logic [REQ_DATA_BITS-1:0] d);
      command_type cmd;
      logic [3:0]  s;
      logic [1:0]  ns;
      logic [15:0] delta;
      bit          finished[SLOT_COUNT];
      int          id;
      cmd   = command_type'(u);
      s     = d[REQ_SLOT_LO +: SLOT_FIELD];
      ns    = d[REQ_NS_LO +: STATE_FIELD];
      delta = d[REQ_DELTA_LO +: TIME_BITS];
      case (cmd)
         CMD_START: begin
            if (head_r >= SLOT_COUNT) begin
               push_outcome(KIND_START, 1'b0, 4'd0, 0, 0, 0, 1'b1);
            end else begin
               id = head_r;
               head_r = link_r[id];
               if (id >= mark_r) mark_r = 5'(id + 1);
               mode_r[id]    = MODE_PLAY;
               tag_r[id]     = d[REQ_TAG_LO +: TAG_BITS];
               length_r[id]  = {1'b0, d[REQ_DUR_LO +: TIME_BITS]};
               elapsed_r[id] = '0;
               org_x[id] = longint'($signed(d[REQ_SX_LO +: COORD_BITS]));
               org_y[id] = longint'($signed(d[REQ_SY_LO +: COORD_BITS]));
               tgt_x[id] = longint'($signed(d[REQ_EX_LO +: COORD_BITS]));
               tgt_y[id] = longint'($signed(d[REQ_EY_LO +: COORD_BITS]));
               cur_x[id] = org_x[id];
               cur_y[id] = org_y[id];
               ever_started[id] <= 1'b1;
               push_outcome(KIND_START, 1'b1, 4'(id), 0, 0, 0, 1'b1);
            end
         end
         CMD_SET: begin
            if (ns == MODE_FREE) begin
               if (mode_r[s] != MODE_FREE) free_slot(s);
            end else if (ns == MODE_PLAY || ns == MODE_PAUSE) begin
               if (mode_r[s] != MODE_FREE) mode_r[s] = mode_type'(ns);
            end
            push_outcome(KIND_DONE, 1'b1, 4'd0, 0, 0, 0, 1'b1);
         end
         CMD_ADVANCE: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               finished[i] = 0;
               if (i >= mark_r || mode_r[i] != MODE_PLAY) continue;
               elapsed_r[i] = elapsed_r[i] + delta;   // wraps at 17 bits
               if (elapsed_r[i] >= length_r[i]) begin
                  finished[i] = 1;
                  cur_x[i] = tgt_x[i];
                  cur_y[i] = tgt_y[i];
               end else begin
                  cur_x[i] = lerp(org_x[i], tgt_x[i], elapsed_r[i], length_r[i]);
                  cur_y[i] = lerp(org_y[i], tgt_y[i], elapsed_r[i], length_r[i]);
               end
            end
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
               if (!finished[i]) continue;
               if (tag_r[i] != 0)
                  push_outcome(KIND_FINISH, 1'b1, 4'(i), tag_r[i], 0, 0, 1'b0);
               free_slot(i);
            end
            push_outcome(KIND_DONE, 1'b1, 4'd0, 0, 0, 0, 1'b1);
         end
         default: push_outcome(KIND_VALUE, 1'b1, s, 0, cur_x[s], cur_y[s], 1'b1);
      endcase
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         outcome_q.delete();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            mode_r[i] = MODE_FREE;
            link_r[i] = 5'(i + 1);
            tag_r[i] = '0; length_r[i] = '0; elapsed_r[i] = '0;
            org_x[i] = 0; org_y[i] = 0; tgt_x[i] = 0; tgt_y[i] = 0;
            cur_x[i] = 0; cur_y[i] = 0;
         end
         head_r = '0;
         mark_r = '0;
         failures = 0;
         ever_started <= '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("response item with no expectation pending: tdata %0h", rsp_tdata);
               failures++;
            end else begin
               o = outcome_q.pop_front();
               compare_field("kind", o.kind, rsp_tuser);
               compare_field("ok", o.ok, rsp_tdata[RSP_OK_LO]);
               compare_field("slot_index", o.slot_index, rsp_tdata[RSP_SLOT_LO +: SLOT_FIELD]);
               compare_field("tag_out", o.tag, rsp_tdata[RSP_TAG_LO +: TAG_BITS]);
               compare_field("value_x", o.vx, rsp_tdata[RSP_VX_LO +: COORD_BITS]);
               compare_field("value_y", o.vy, rsp_tdata[RSP_VY_LO +: COORD_BITS]);
               compare_field("last", o.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
      end
      pending = outcome_q.size();
   end

endmodule

// ===== test/testbench.sv =====
// Testbench top for the interpolation slot engine: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on ist_pkg, ist_checker and the block.
`timescale 1ns / 1ps
module testbench import ist_pkg::*; ();

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_tvalid = 0;
   logic                     req_tready;
   logic [CMD_BITS-1:0]      req_tuser = '0;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]               rsp_tuser;
   logic                     rsp_tlast;

   int                       failures, pending;
   logic [SLOT_COUNT-1:0]    ever_started;
   int                       send_idle_pct = 0;
   int                       recv_idle_pct = 0;
   logic                     hold_request = 0;
   logic                     holding = 0;

   interpolation_slot_engine u_top (.*);

   ist_checker u_checker (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (reset || holding) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // long receiver stall so the block backs up into its input
   initial begin
      wait (hold_request);
      @(posedge clock);
      holding <= 1'b1;
      repeat (400) @(posedge clock);
      holding <= 1'b0;
   end

   function automatic logic [REQ_DATA_BITS-1:0] pack_item(int s, int ns,
         int delta, int dur, logic [31:0] tag, int sx, int sy, int ex, int ey);
      logic [REQ_DATA_BITS-1:0] d;
      d = '0;
      d[REQ_SLOT_LO +: SLOT_FIELD]  = 4'(s);
      d[REQ_NS_LO +: STATE_FIELD]   = 2'(ns);
      d[REQ_DELTA_LO +: TIME_BITS]  = 16'(delta);
      d[REQ_DUR_LO +: TIME_BITS]    = 16'(dur);
      d[REQ_TAG_LO +: TAG_BITS]     = tag;
      d[REQ_SX_LO +: COORD_BITS]    = 16'(sx);
      d[REQ_SY_LO +: COORD_BITS]    = 16'(sy);
      d[REQ_EX_LO +: COORD_BITS]    = 16'(ex);
      d[REQ_EY_LO +: COORD_BITS]    = 16'(ey);
      return d;
   endfunction

   task automatic send_item(command_type cmd, logic [REQ_DATA_BITS-1:0] d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic start_slot(int dur, logic [31:0] tag, int sx, int sy, int ex, int ey);
      send_item(CMD_START, pack_item($urandom_range(0, 15), $urandom_range(0, 3),
                          $urandom_range(0, 65535), dur, tag, sx, sy, ex, ey));
   endtask

   task automatic set_slot(int s, int ns);
      send_item(CMD_SET, pack_item(s, ns, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom));
   endtask

   task automatic advance(int delta);
      send_item(CMD_ADVANCE, pack_item($urandom_range(0, 15), $urandom_range(0, 3), delta,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
   endtask

   task automatic read_slot(int s);
      send_item(CMD_READ, pack_item(s, $urandom_range(0, 3), $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom));
   endtask

   task automatic random_item();
      int pick, s;
      pick = $urandom_range(0, 99);
      s    = $urandom_range(0, 15);
      if (pick < 30 || ever_started == '0) begin
         start_slot(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 400),
                    ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
                    $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 50) begin
         set_slot(s, $urandom_range(0, 3));
      end else if (pick < 75) begin
         advance(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 120));
      end else begin
         while (!ever_started[s]) s = $urandom_range(0, 15);
         read_slot(s);
      end
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero duration, silent tag, pause and odd state values
      start_slot(65535, 32'hffffffff, -32768, 32767, 32767, -32768);
      start_slot(0, 32'd0, 0, 0, -1, 1);
      start_slot(100, 32'h5a5a_a5a5, -32768, -32768, 32767, 32767);
      read_slot(0);
      set_slot(2, MODE_PAUSE);
      advance(50);
      read_slot(0);
      read_slot(1);
      read_slot(2);
      set_slot(2, MODE_PLAY);
      set_slot(1, 3);
      set_slot(1, MODE_PLAY);
      set_slot(1, MODE_FREE);
      advance(65535);
      read_slot(0);
      set_slot(0, MODE_FREE);
      for (int i = 0; i < 17; i++)
         start_slot(1000, i, i * 1000, -i * 1000, -i, i);
      set_slot(15, MODE_FREE);
      set_slot(15, MODE_FREE);
      set_slot(15, MODE_PLAY);
      read_slot(15);
      advance(65535);
      advance(65535);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 78 : 0;
         recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 17 : 0;
         for (int n = 0; n < 61; n++) begin
            if (phase == 2 && n == 10) hold_request <= 1'b1;
            random_item();
         end
      end
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (400) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
